>>> design/cht_pkg.sv
// Package for the chained hash table.
// Request and response field widths and the request mode codes.
// No dependencies.
package cht_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

endpackage

>>> design/cht_if.sv
// Request and response channel interfaces of the chained hash table.
// Depends on cht_pkg.
interface cht_req_if import cht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface cht_rsp_if import cht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [VALUE_W-1:0] result_value;
  logic               status;

  modport source (output valid, found, result_value, status, input ready);
  modport sink   (input valid, found, result_value, status, output ready);
endinterface

>>> design/chained_hash_table.sv
// Chained hash table top level: request sequencer, slot RAM, modulo unit.
// Depends on cht_pkg, cht_if, cht_ram, cht_mod.
//
// Channel  | Dir | Payload
// req_i    | in  | mode, key, value
// rsp_o    | out | found, result_value, status
//
// After reset a clearing pass writes all 2*BUCKETS slots, one per cycle;
// no request is taken during it.
// A request is accepted and hashed (a mask, or a byte-wise reduction when
// BUCKETS is not a power of two); its chain is then walked one link at a time
// through the single slot RAM read port, up to two slot writes follow, and
// the response is posted.
// One request at a time; a response held by a stalled sink holds the next
// response back, not the next request.
module chained_hash_table import cht_pkg::*; #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cht_req_if.sink    req_i,
  cht_rsp_if.source  rsp_o
);

  localparam int unsigned SLOTS = 2 * BUCKETS;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned OW    = $clog2(BUCKETS + 1);

  typedef struct packed {
    logic                  used;
    logic                  last;
    logic [SW-1:0]         nxt;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  localparam int unsigned WW = $bits(slot_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_EVAL, S_EVAL_NX, S_WRITE2, S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [SW-1:0]         clr_q, clr_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [SW-1:0]         prev_q, prev_d;
  logic                  prev_v_q, prev_v_d;
  slot_t                 prev_w_q, prev_w_d;
  logic [SW-1:0]         w2_addr_q, w2_addr_d;
  slot_t                 w2_data_q, w2_data_d;
  logic [OW-1:0]         ovf_q, ovf_d;
  logic                  res_found_q, res_found_d;
  logic [VALUE_W-1:0]    res_value_q, res_value_d;
  logic                  res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [VALUE_W-1:0]    out_value_q, out_value_d;
  logic                  out_status_q, out_status_d;

  logic                  we;
  logic [SW-1:0]         waddr;
  slot_t                 wdata;
  logic [SW-1:0]         raddr;
  logic [WW-1:0]         rdata;
  slot_t                 w;
  slot_t                 fresh;
  slot_t                 tmp;
  logic                  accept;
  logic                  mod_done;
  logic [SW-1:0]         mod_rem;
  logic                  match;

  assign accept = req_i.valid && req_i.ready;
  assign w      = slot_t'(rdata);
  assign match  = w.used && (w.key == key_q);

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.status       = out_status_q;

  cht_mod #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (KEY_BITS'(req_i.key)),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  cht_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer next state, RAM port and result
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_v_d     = prev_v_q;
    prev_w_d     = prev_w_q;
    w2_addr_d    = w2_addr_q;
    w2_data_d    = w2_data_q;
    ovf_d        = ovf_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    we           = 1'b0;
    waddr        = cur_q;
    wdata        = w;
    raddr        = cur_q;
    fresh        = '{used: 1'b1, last: 1'b1, nxt: '0, key: key_q, val: value_q};
    tmp          = w;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d       = req_i.mode;
          key_d        = KEY_BITS'(req_i.key);
          value_d      = VALUE_BITS'(req_i.value);
          prev_v_d     = 1'b0;
          res_found_d  = 1'b0;
          res_value_d  = '0;
          res_status_d = 1'b0;
          if (req_i.mode == MODE_INSERT || req_i.mode == MODE_LOOKUP ||
              req_i.mode == MODE_REMOVE) begin
            state_d = S_HASH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_HASH: begin
        raddr = mod_rem;
        if (mod_done) begin
          cur_d   = mod_rem;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        raddr   = w.nxt;
        state_d = S_DONE;
        if (!prev_v_q && !w.used) begin
          // Empty bucket head
          if (mode_q == MODE_INSERT) begin
            we    = 1'b1;
            wdata = fresh;
          end
        end else if (match) begin
          res_found_d = 1'b1;
          case (mode_q)
            MODE_INSERT: begin
              we      = 1'b1;
              tmp.val = value_q;
              wdata   = tmp;
            end
            MODE_LOOKUP: begin
              res_value_d = VALUE_W'(w.val);
            end
            MODE_REMOVE: begin
              if (!prev_v_q) begin
                if (w.last) begin
                  we       = 1'b1;
                  tmp.used = 1'b0;
                  tmp.last = 1'b0;
                  wdata    = tmp;
                end else begin
                  // Head takes over its successor; read it now
                  w2_addr_d = w.nxt;
                  state_d   = S_EVAL_NX;
                end
              end else begin
                // Relink the predecessor, then free this slot
                we    = 1'b1;
                waddr = prev_q;
                tmp   = prev_w_q;
                if (w.last) begin
                  tmp.last = 1'b1;
                end else begin
                  tmp.nxt  = w.nxt;
                  tmp.last = 1'b0;
                end
                wdata          = tmp;
                w2_addr_d      = cur_q;
                w2_data_d      = w;
                w2_data_d.used = 1'b0;
                w2_data_d.last = 1'b0;
                state_d        = S_WRITE2;
              end
            end
            default: begin
              res_found_d = 1'b0;
            end
          endcase
        end else if (w.last) begin
          // Chain tail reached without a match
          if (mode_q == MODE_INSERT) begin
            if (ovf_q < OW'(BUCKETS)) begin
              we        = 1'b1;
              tmp.nxt   = SW'(BUCKETS) + SW'(ovf_q);
              tmp.last  = 1'b0;
              wdata     = tmp;
              w2_addr_d = SW'(BUCKETS) + SW'(ovf_q);
              w2_data_d = fresh;
              ovf_d     = ovf_q + 1'b1;
              state_d   = S_WRITE2;
            end else begin
              res_status_d = 1'b1;
            end
          end
        end else begin
          // Follow the link
          prev_d   = cur_q;
          prev_w_d = w;
          prev_v_d = 1'b1;
          cur_d    = w.nxt;
          state_d  = S_EVAL;
        end
      end
      S_EVAL_NX: begin
        we             = 1'b1;
        waddr          = cur_q;
        wdata          = w;
        wdata.used     = 1'b1;
        w2_data_d      = w;
        w2_data_d.used = 1'b0;
        w2_data_d.last = 1'b0;
        state_d        = S_WRITE2;
      end
      S_WRITE2: begin
        we      = 1'b1;
        waddr   = w2_addr_q;
        wdata   = w2_data_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ovf_q       <= '0;
      prev_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ovf_q       <= ovf_d;
      prev_v_q    <= prev_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_w_q     <= prev_w_d;
    w2_addr_q    <= w2_addr_d;
    w2_data_q    <= w2_data_d;
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

endmodule

>>> design/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/cht_mod.sv
// Key modulo bucket count: mask for a power-of-two count, otherwise one key
// byte at a time, each reduced by a reciprocal multiply and then a subtract.
// No dependencies.
module cht_mod #(
  parameter int unsigned BUCKETS  = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [KEY_BITS-1:0]              key_i,
  output logic                             done_o,
  output logic [$clog2(2*BUCKETS)-1:0]     rem_o
);

  localparam int unsigned SW   = $clog2(2*BUCKETS);
  localparam bit          POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic [SW-1:0] rem_q;

  assign rem_o = rem_q;

  if (POW2) begin : g_mask
    // Power-of-two count: low key bits are the bucket
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
      end else if (start_i) begin
        rem_q <= SW'(key_i % BUCKETS);
      end
    end
    assign done_o = 1'b1;
  end else begin : g_recip
    localparam int unsigned BW  = $clog2(BUCKETS);
    localparam int unsigned VW  = BW + 8;
    localparam int unsigned MW  = VW + 1;
    localparam int unsigned PW  = VW + MW;
    localparam int unsigned SH  = VW + BW;
    localparam int unsigned NCH = (KEY_BITS + 7) / 8;
    localparam int unsigned KP  = NCH * 8;
    localparam int unsigned CW  = $clog2(NCH + 1);
    localparam longint unsigned MUL_L =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MW-1:0] MUL = MW'(MUL_L);

    logic [KP-1:0] sh_q;
    logic [CW-1:0] cnt_q;
    logic          busy_q;
    logic          ph_q;
    logic [7:0]    quo_q;
    logic [VW-1:0] dvd;
    logic [PW-1:0] prod;
    logic [VW-1:0] qb;

    // Partial remainder with the next key byte appended
    assign dvd  = {rem_q[BW-1:0], sh_q[KP-1 -: 8]};
    // Exact quotient digit by reciprocal multiply, then its multiple
    assign prod = PW'(dvd) * PW'(MUL);
    assign qb   = VW'(quo_q) * VW'(BUCKETS);

    // Sequencer: phase 0 forms the digit, phase 1 the new remainder
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        ph_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        ph_q <= !ph_q;
        if (ph_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(NCH - 1)) begin
            busy_q <= 1'b0;
          end
        end
      end
    end

    // Datapath
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= KP'(key_i);
        rem_q <= '0;
      end else if (busy_q) begin
        if (!ph_q) begin
          quo_q <= prod[SH +: 8];
        end else begin
          rem_q <= SW'(dvd - qb);
          sh_q  <= sh_q << 8;
        end
      end
    end

    assign done_o = !busy_q;
  end

endmodule

>>> design/cht_checker.sv
// Port-level checks for the chained hash table, bound to the top level.
// Depends on cht_pkg and chained_hash_table.
module cht_checker import cht_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               rsp_found_i,
  input logic [VALUE_W-1:0] rsp_value_i,
  input logic               rsp_status_i
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_found_i) &&
    $stable(rsp_value_i) && $stable(rsp_status_i))
    else $error("response changed while stalled");

  // A full table never reports a hit
  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_status_i && rsp_found_i))
    else $error("full status with found");

  // A value is returned only on a hit
  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_value_i != '0) |-> rsp_found_i)
    else $error("value without hit");

  // One request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_found_i  (rsp_o.found),
  .rsp_value_i  (rsp_o.result_value),
  .rsp_status_i (rsp_o.status)
);
